@@ rtl/rtfl_pkg.sv @@
// Shared constants for the region table fault lookup and insert unit.
// Port field widths and status codes; no dependencies.
`timescale 1ns / 1ps

package rtfl_pkg;

    // Widths of the fixed port fields
    localparam int FIELD_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    // Status codes returned with each result
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_BEYOND = 2'd2;

endpackage

@@ rtl/region_table_fault_lookup_insert_unit.sv @@
// Region table fault lookup and insert unit: sorted region table in one
// synchronous memory, scanned per fault and shifted on insertion.
// Depends on rtfl_pkg.
//
// Sequence after an input transfer: a hit at sorted position p is found by reading
// entries 0 to p; a miss below region p that answers an error goes on to S_DECIDE;
// a miss below region p that inserts first shifts the n - p regions above it; a
// miss above all n stored regions reads all n, then inserts or answers an error.
// One fault is in work at a time; the next is taken while a finished result
// waits in the output register.
// Reset empties the table (count to zero) and sets dataspace_size to all ones.
`timescale 1ns / 1ps

module region_table_fault_lookup_insert_unit #(
    parameter int MAX_REGIONS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rtfl_pkg::FIELD_W-1:0]          cfg_data,
    // Fault input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rtfl_pkg::FIELD_W-1:0]          fault_offset,
    // Result output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rtfl_pkg::FIELD_W-1:0]          region_start,
    output logic [rtfl_pkg::FIELD_W-1:0]          region_length,
    output logic [rtfl_pkg::SLOT_W-1:0]           slot,
    output logic                                  created,
    output logic [rtfl_pkg::STATUS_W-1:0]         status
);

    localparam int OB    = OFFSET_BITS;
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int FW    = rtfl_pkg::FIELD_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REGIONS);

    typedef logic [2*OB-1:0] entry_t;

    // Region memory: {start, length} per sorted position
    entry_t                mem [MAX_REGIONS];
    entry_t                rd_data_reg;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_ra;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    entry_t                mem_wd;

    logic [2:0]            state_reg, state_next;
    logic [OB-1:0]         size_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      sh_reg, sh_next;
    logic [OB-1:0]         off_reg, off_next;
    logic [OB:0]           prev_end_reg, prev_end_next;
    logic [OB-1:0]         next_start_reg, next_start_next;
    logic                  next_hit_reg, next_hit_next;

    logic [OB-1:0]         res_start_reg, res_start_next;
    logic [OB-1:0]         res_len_reg, res_len_next;
    logic [IDX_W-1:0]      res_slot_reg, res_slot_next;
    logic                  res_created_reg, res_created_next;
    rtfl_pkg::status_t     res_status_reg, res_status_next;

    logic                  out_valid_reg;
    logic [FW-1:0]         out_start_reg;
    logic [FW-1:0]         out_len_reg;
    logic [rtfl_pkg::SLOT_W-1:0] out_slot_reg;
    logic                  out_created_reg;
    rtfl_pkg::status_t     out_status_reg;

    logic                  out_load;
    logic [63:0]           off_wide;
    logic [63:0]           cfg_wide;
    logic [63:0]           start_wide;
    logic [63:0]           len_wide;
    logic [IDX_W+3:0]      slot_wide;
    logic [OB-1:0]         rd_start;
    logic [OB-1:0]         rd_len;
    logic [OB:0]           rd_end;
    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      sh_dec;
    logic [OB-1:0]         gap_hi;

    // Port width adaption between the 32-bit fields and the offset width
    always_comb
    begin
        off_wide               = '0;
        off_wide[FW-1:0]       = fault_offset;
        cfg_wide               = '0;
        cfg_wide[FW-1:0]       = cfg_data;
        start_wide             = '0;
        start_wide[OB-1:0]     = res_start_reg;
        len_wide               = '0;
        len_wide[OB-1:0]       = res_len_reg;
        slot_wide              = '0;
        slot_wide[IDX_W-1:0]   = res_slot_reg;
    end

    // Split the registered read data and form the region end
    assign rd_start = rd_data_reg[2*OB-1:OB];
    assign rd_len   = rd_data_reg[OB-1:0];
    assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
    assign idx_inc  = idx_reg + 1'b1;
    assign sh_dec   = sh_reg - 1'b1;
    assign gap_hi   = next_hit_reg ? next_start_reg : size_reg;

    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer: scan, decide, shift and insert
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        sh_next          = sh_reg;
        off_next         = off_reg;
        prev_end_next    = prev_end_reg;
        next_start_next  = next_start_reg;
        next_hit_next    = next_hit_reg;
        res_start_next   = res_start_reg;
        res_len_next     = res_len_reg;
        res_slot_next    = res_slot_reg;
        res_created_next = res_created_reg;
        res_status_next  = res_status_reg;
        mem_re           = 1'b0;
        mem_ra           = '0;
        mem_we           = 1'b0;
        mem_wa           = '0;
        mem_wd           = {res_start_reg, res_len_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    off_next      = off_wide[OB-1:0];
                    idx_next      = '0;
                    prev_end_next = '0;
                    next_hit_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_ra     = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_end <= {1'b0, off_reg})
                begin
                    // Region ends at or below the offset: step past it
                    prev_end_next = rd_end;
                    idx_next      = idx_inc;
                    if (idx_inc == count_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_ra = idx_inc[IDX_W-1:0];
                    end
                end
                else if (off_reg >= rd_start)
                begin
                    // Hit: return the stored region
                    res_start_next   = rd_start;
                    res_len_next     = rd_len;
                    res_slot_next    = idx_reg[IDX_W-1:0];
                    res_created_next = 1'b0;
                    res_status_next  = rtfl_pkg::ST_OK;
                    state_next       = S_DONE;
                end
                else
                begin
                    // Offset lies in the gap below this region
                    next_start_next = rd_start;
                    next_hit_next   = 1'b1;
                    state_next      = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (off_reg >= size_reg)
                begin
                    res_start_next   = '0;
                    res_len_next     = '0;
                    res_slot_next    = '0;
                    res_created_next = 1'b0;
                    res_status_next  = rtfl_pkg::ST_BEYOND;
                    state_next       = S_DONE;
                end
                else if (count_reg == CNT_FULL)
                begin
                    res_start_next   = '0;
                    res_len_next     = '0;
                    res_slot_next    = '0;
                    res_created_next = 1'b0;
                    res_status_next  = rtfl_pkg::ST_FULL;
                    state_next       = S_DONE;
                end
                else
                begin
                    // New region fills the whole gap
                    res_start_next   = prev_end_reg[OB-1:0];
                    res_len_next     = gap_hi - prev_end_reg[OB-1:0];
                    res_slot_next    = idx_reg[IDX_W-1:0];
                    res_created_next = 1'b1;
                    res_status_next  = rtfl_pkg::ST_OK;
                    if (count_reg == idx_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_wa     = idx_reg[IDX_W-1:0];
                        mem_wd     = {prev_end_reg[OB-1:0], gap_hi - prev_end_reg[OB-1:0]};
                        count_next = count_reg + 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Start the shift from the top entry down
                        mem_re     = 1'b1;
                        mem_ra     = IDX_W'(count_reg - 1'b1);
                        sh_next    = count_reg;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Move entry sh-1 up to sh, read the next one below
                mem_we = 1'b1;
                mem_wa = sh_reg[IDX_W-1:0];
                mem_wd = rd_data_reg;
                if (sh_dec == idx_reg)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    mem_re  = 1'b1;
                    mem_ra  = IDX_W'(sh_dec - 1'b1);
                    sh_next = sh_dec;
                end
            end

            S_INSERT:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg[IDX_W-1:0];
                mem_wd     = {res_start_reg, res_len_reg};
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Region memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Reset value of the size register: 32 ones, cut to the offset width
    function automatic logic [OB-1:0] cfg_wide_reset();
        logic [63:0] ones;
        ones        = '0;
        ones[FW-1:0] = '1;
        return ones[OB-1:0];
    endfunction

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            size_reg      <= cfg_wide_reset();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid)
            begin
                size_reg <= cfg_wide[OB-1:0];
            end
            // Hold the result until the transfer, then drop valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Work and result payload
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        sh_reg          <= sh_next;
        off_reg         <= off_next;
        prev_end_reg    <= prev_end_next;
        next_start_reg  <= next_start_next;
        next_hit_reg    <= next_hit_next;
        res_start_reg   <= res_start_next;
        res_len_reg     <= res_len_next;
        res_slot_reg    <= res_slot_next;
        res_created_reg <= res_created_next;
        res_status_reg  <= res_status_next;
        if (out_load)
        begin
            out_start_reg   <= start_wide[FW-1:0];
            out_len_reg     <= len_wide[FW-1:0];
            out_slot_reg    <= slot_wide[rtfl_pkg::SLOT_W-1:0];
            out_created_reg <= res_created_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign region_start  = out_start_reg;
    assign region_length = out_len_reg;
    assign slot          = out_slot_reg;
    assign created       = out_created_reg;
    assign status        = out_status_reg;

endmodule

@@ tb/sv/region_table_fault_lookup_insert_unit_tb.sv @@
// Self-checking testbench for the region table fault lookup and insert unit.
// Feeds fault offsets through a valid/ready driver, predicts each answer from
// a local copy of the sorted region table and checks every result transfer.
// Depends on rtfl_pkg and region_table_fault_lookup_insert_unit.
`timescale 1ns / 1ps

module region_table_fault_lookup_insert_unit_tb;

    localparam int MAX_REGIONS = 16;
    localparam int PHASES      = 31;
    localparam int PHASE_ITEMS = 24;
    localparam int RX_HOLD     = 400;
    localparam int HOLD_PHASE  = 10;
    localparam int SETTLE      = 60;

    typedef struct packed {
        logic [rtfl_pkg::FIELD_W-1:0] start;
        logic [rtfl_pkg::FIELD_W-1:0] length;
        logic [rtfl_pkg::SLOT_W-1:0]  slot;
        logic                         created;
        rtfl_pkg::status_t            st;
    } region_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rtfl_pkg::FIELD_W-1:0]  cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [rtfl_pkg::FIELD_W-1:0]  fault_offset = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [rtfl_pkg::FIELD_W-1:0]  region_start;
    logic [rtfl_pkg::FIELD_W-1:0]  region_length;
    logic [rtfl_pkg::SLOT_W-1:0]   slot;
    logic                          created;
    logic [rtfl_pkg::STATUS_W-1:0] status;

    // Local copy of the region table and the size register
    logic [rtfl_pkg::FIELD_W-1:0]  tbl_start [MAX_REGIONS];
    logic [rtfl_pkg::FIELD_W-1:0]  tbl_len   [MAX_REGIONS];
    int                            tbl_count = 0;
    logic [rtfl_pkg::FIELD_W-1:0]  ds_size = '1;

    logic [rtfl_pkg::FIELD_W-1:0]  fault_q[$];
    region_result_t                answer_q[$];

    int  in_xfer_cnt = 0;
    int  err_cnt = 0;
    int  n_hit = 0, n_ins = 0, n_full = 0, n_beyond = 0, n_size_writes = 0;
    logic calm;
    logic rx_hold_req = 1'b0;
    logic hold_done;
    int  hold_left;

    region_table_fault_lookup_insert_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .fault_offset (fault_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .region_start (region_start),
        .region_length(region_length),
        .slot         (slot),
        .created      (created),
        .status       (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // No random idling on either side over this stretch of transfers
    assign calm = (in_xfer_cnt >= 300) && (in_xfer_cnt < 420);

    // End offset of a stored region, one bit wider so it cannot wrap
    function automatic logic [rtfl_pkg::FIELD_W:0] region_end(input int j);
        return {1'b0, tbl_start[j]} + {1'b0, tbl_len[j]};
    endfunction

    // Find the region holding the offset, or fill the gap around it
    function automatic region_result_t lookup_or_insert(
        input logic [rtfl_pkg::FIELD_W-1:0] off
    );
        region_result_t                r;
        int                            i;
        int                            k;
        logic [rtfl_pkg::FIELD_W:0]    lo;
        logic [rtfl_pkg::FIELD_W-1:0]  hi;
        r = '0;
        i = 0;
        while (i < tbl_count && region_end(i) <= {1'b0, off})
            i++;
        if (i < tbl_count && off >= tbl_start[i])
        begin
            r.start  = tbl_start[i];
            r.length = tbl_len[i];
            r.slot   = i[rtfl_pkg::SLOT_W-1:0];
            r.st     = rtfl_pkg::ST_OK;
            n_hit++;
        end
        else if (off >= ds_size)
        begin
            r.st = rtfl_pkg::ST_BEYOND;
            n_beyond++;
        end
        else if (tbl_count >= MAX_REGIONS)
        begin
            r.st = rtfl_pkg::ST_FULL;
            n_full++;
        end
        else
        begin
            hi = (i < tbl_count) ? tbl_start[i] : ds_size;
            lo = (i > 0) ? region_end(i - 1) : '0;
            for (k = tbl_count; k > i; k--)
            begin
                tbl_start[k] = tbl_start[k - 1];
                tbl_len[k]   = tbl_len[k - 1];
            end
            tbl_start[i] = lo[rtfl_pkg::FIELD_W-1:0];
            tbl_len[i]   = hi - lo[rtfl_pkg::FIELD_W-1:0];
            tbl_count++;
            r.start   = tbl_start[i];
            r.length  = tbl_len[i];
            r.slot    = i[rtfl_pkg::SLOT_W-1:0];
            r.created = 1'b1;
            r.st      = rtfl_pkg::ST_OK;
            n_ins++;
        end
        return r;
    endfunction

    // Offer queued faults; hold each one until its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            fault_offset <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (fault_q.size() != 0 && (calm || $urandom_range(99) >= 15))
            begin
                in_valid     <= 1'b1;
                fault_offset <= fault_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Count down the long receiver hold-off once it is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (rx_hold_req && !hold_done)
        begin
            hold_left <= RX_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Drive the result ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 15);
    end

    // Track size writes, predict on fault transfers, check result transfers
    always @(posedge clk or negedge rst_n)
    begin
        region_result_t exp_r;
        region_result_t got_r;
        if (!rst_n)
        begin
            tbl_count = 0;
            ds_size   = '1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ds_size = cfg_data;
                n_size_writes++;
            end
            if (in_valid && in_ready)
            begin
                answer_q.push_back(lookup_or_insert(fault_offset));
                in_xfer_cnt++;
            end
            if (out_valid && out_ready)
            begin
                got_r = '{region_start, region_length, slot, created, status};
                if (answer_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"ERROR: result with none pending: ",
                                  "start=%h len=%h slot=%0d created=%0b status=%0d"},
                                 region_start, region_length, slot, created, status);
                end
                else
                begin
                    exp_r = answer_q.pop_front();
                    if (got_r.start !== exp_r.start || got_r.length !== exp_r.length ||
                        got_r.slot !== exp_r.slot || got_r.created !== exp_r.created ||
                        got_r.st !== exp_r.st)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"ERROR: expected start=%h len=%h slot=%0d ",
                                      "created=%0b status=%0d, got start=%h len=%h ",
                                      "slot=%0d created=%0b status=%0d"},
                                     exp_r.start, exp_r.length, exp_r.slot,
                                     exp_r.created, exp_r.st,
                                     got_r.start, got_r.length, got_r.slot,
                                     got_r.created, got_r.st);
                    end
                end
            end
        end
    end

    // Wait until every queued fault has been answered
    task automatic drain();
        while (fault_q.size() != 0 || in_valid || answer_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the dataspace size; the block is idle here
    task automatic write_size(input logic [rtfl_pkg::FIELD_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                            ph;
        int                            n;
        int                            j;
        int unsigned                   pick;
        logic [rtfl_pkg::FIELD_W:0]    top_end;
        logic [rtfl_pkg::FIELD_W:0]    span;
        logic [rtfl_pkg::FIELD_W:0]    sum;
        logic [rtfl_pkg::FIELD_W:0]    beyond_lo;
        logic [rtfl_pkg::FIELD_W-1:0]  new_size;
        logic [rtfl_pkg::FIELD_W-1:0]  off;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table at reset size: the top offset lies beyond the size
        fault_q.push_back('1);
        drain();

        // Zero size: every miss is beyond the size
        write_size('0);
        fault_q.push_back('0);
        fault_q.push_back(32'd5);
        drain();

        // Smallest size: one-byte region, then hits and misses past it
        write_size(32'd1);
        fault_q.push_back('0);
        fault_q.push_back('0);
        fault_q.push_back(32'd1);
        fault_q.push_back('1);
        drain();

        // Second region fills the gap up to the size
        write_size(32'h100);
        fault_q.push_back(32'hff);
        fault_q.push_back(32'd1);
        fault_q.push_back(32'h100);
        fault_q.push_back('0);
        drain();

        // Size lowered below stored regions: lookup still wins
        write_size(32'h10);
        fault_q.push_back(32'h80);
        fault_q.push_back(32'hff);
        fault_q.push_back(32'h100);
        fault_q.push_back(32'h8000_0000);
        drain();

        // Random phases: new size, then a mix of hits, gap misses and far misses
        for (ph = 0; ph < PHASES; ph++)
        begin
            top_end = (tbl_count > 0) ? region_end(tbl_count - 1) : '0;
            pick = $urandom_range(9);
            if ((pick == 7 || pick == 8) && tbl_count < 12)
                pick = 0;
            case (pick)
                6: new_size = $urandom_range(top_end[rtfl_pkg::FIELD_W-1:0], 0);
                7: new_size = '1;
                8: new_size = $urandom;
                9: new_size = top_end[rtfl_pkg::FIELD_W-1:0];
                default:
                begin
                    case ($urandom_range(3))
                        0: span = $urandom_range(4, 1);
                        1: span = $urandom_range(1000, 1);
                        2: span = $urandom_range(1 << 20, 1);
                        default: span = $urandom_range(1 << 28, 1);
                    endcase
                    sum = top_end + span;
                    new_size = sum[rtfl_pkg::FIELD_W] ? '1 : sum[rtfl_pkg::FIELD_W-1:0];
                end
            endcase
            if (ph == PHASES - 1)
                new_size = '1;
            write_size(new_size);

            if (ph == HOLD_PHASE)
                rx_hold_req <= 1'b1;

            beyond_lo = ({1'b0, new_size} > top_end) ? {1'b0, new_size} : top_end;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                off  = $urandom;
                if (pick < 40 && tbl_count > 0)
                begin
                    j = $urandom_range(tbl_count - 1, 0);
                    case ($urandom_range(2))
                        0: off = tbl_start[j];
                        1: off = tbl_start[j] + tbl_len[j] - 1;
                        default: off = tbl_start[j] + ($urandom % tbl_len[j]);
                    endcase
                end
                else if (pick < 60 && {1'b0, new_size} > top_end)
                begin
                    off = $urandom_range(new_size - 1, top_end[rtfl_pkg::FIELD_W-1:0]);
                end
                else if (pick < 75 && beyond_lo[rtfl_pkg::FIELD_W] == 1'b0)
                begin
                    off = $urandom_range(32'hffff_ffff,
                                         beyond_lo[rtfl_pkg::FIELD_W-1:0]);
                end
                fault_q.push_back(off);
            end
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        $display("Run covered %0d faults over %0d size writes: %0d hits, %0d inserts,",
                 in_xfer_cnt, n_size_writes, n_hit, n_ins);
        $display("%0d table-full and %0d beyond-size answers, %0d regions stored at the end.",
                 n_full, n_beyond, tbl_count);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop for a hung run
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
